// ===== src/llhq_pkg.sv =====
package llhq_pkg;

  // Histogram geometry
  localparam int NUM_BINS   = 32;
  localparam int NUM_AXES   = 3;
  localparam int EDGE_STEPS = 32;
  localparam int DEPTH      = NUM_BINS * NUM_AXES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int EIDX_W     = $clog2(EDGE_STEPS + 1);

  // Field and datapath widths
  localparam int AXIS_W = 2;
  localparam int MAG_W  = 20;
  localparam int P_W    = 17;
  localparam int LVL_W  = 17;
  localparam int SH_W   = 5;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = CNT_W + BIN_W;
  localparam int ITER   = 17;
  localparam int PROD_W = TOT_W + ITER;
  localparam int TG_W   = PROD_W - 16;
  localparam int W10    = TOT_W + 4;

  localparam logic [SH_W-1:0]  SHIFT_MIN = 5'd1;
  localparam logic [SH_W-1:0]  SHIFT_MAX = 5'd20;
  localparam logic [SH_W-1:0]  SHIFT_RST = 5'd11;
  localparam logic [LVL_W-1:0] TOP_LEVEL = 17'd65536;

  // Log-spaced bin edges, round(64*2^(10i/32)), last one 65536
  localparam logic [LVL_W-1:0] EDGE_TABLE [EDGE_STEPS+1] = '{
    17'd64,    17'd79,    17'd99,    17'd123,   17'd152,   17'd189,   17'd235,   17'd292,
    17'd362,   17'd450,   17'd558,   17'd693,   17'd861,   17'd1069,  17'd1328,  17'd1649,
    17'd2048,  17'd2543,  17'd3158,  17'd3922,  17'd4871,  17'd6049,  17'd7512,  17'd9329,
    17'd11585, 17'd14387, 17'd17867, 17'd22188, 17'd27554, 17'd34219, 17'd42495, 17'd52773,
    17'd65536
  };

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUANT = 2'd1,
    ACT_TAIL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SUM,
    ST_QMUL,
    ST_QSCAN,
    ST_QMUL2,
    ST_QDIV,
    ST_TSCAN,
    ST_TDIV,
    ST_DONE
  } state_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  // Command to the shared multiply/divide unit
  typedef struct packed {
    logic              go;
    md_op_e            op;
    logic [PROD_W-1:0] x;   // multiplier (low ITER bits) or dividend
    logic [TOT_W-1:0]  y;   // multiplicand or divisor
  } md_cmd_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] res;  // product, or quotient in the low ITER bits
  } md_rsp_t;

  // Lower edge of bin i; i = NUM_BINS gives the top level
  function automatic logic [LVL_W-1:0] edge_at(input logic [BIN_W:0] i);
    logic [LVL_W-1:0] e;
    if (int'(i) >= NUM_BINS) begin
      e = TOP_LEVEL;
    end else begin
      e = EDGE_TABLE[EIDX_W'((int'(i) * EDGE_STEPS) / NUM_BINS)];
    end
    return e;
  endfunction

endpackage

// ===== src/leaky_log_histogram_quantile.sv =====
// Leaky log-spaced histograms with quantile and tail-mass queries.
// Input words enter on s_axis_*: tuser carries the action (add sample,
// quantile query, tail query), tdata the axis, error magnitude and
// probability. Each input word gives exactly one result word on m_axis_*.
// leak_shift is written through cfg_valid_i/cfg_data_i at any time the
// block is idle; cfg_ready_o is always high.
// One word is processed at a time, s_axis_tready is high only when idle.
// Each pass over an axis reads the 32 bins through the single RAM read
// port, one bin per cycle, and the shared multiply/divide unit answers
// each command it is given. A bad axis or the none action skips the
// scans and goes straight to the result.
// After reset a clearing pass writes zero to all 96 counters, with
// s_axis_tready low; leak_shift resets to 11.
// A result waits in an output register; the next word is taken meanwhile,
// and its result is held back until m_axis_tready takes the pending one.
module leaky_log_histogram_quantile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // axis[1:0], error_mag[21:2], quantile_p[38:22]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // level[16:0], tail_fraction[33:17]
  output logic [1:0]  m_axis_tuser,   // hist_empty[0], bad_axis[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int NB     = llhq_pkg::NUM_BINS;
  localparam int ADDR_W = llhq_pkg::ADDR_W;
  localparam int BIN_W  = llhq_pkg::BIN_W;
  localparam int TOT_W  = llhq_pkg::TOT_W;
  localparam int CNT_W  = llhq_pkg::CNT_W;
  localparam int PROD_W = llhq_pkg::PROD_W;
  localparam int TG_W   = llhq_pkg::TG_W;
  localparam int W10    = llhq_pkg::W10;
  localparam int LVL_W  = llhq_pkg::LVL_W;
  localparam int MAG_W  = llhq_pkg::MAG_W;
  localparam int P_W    = llhq_pkg::P_W;
  localparam int SH_W   = llhq_pkg::SH_W;

  llhq_pkg::state_e       state_q, state_d;
  logic [SH_W-1:0]        shift_q;
  logic [SH_W-1:0]        sh;
  logic [ADDR_W-1:0]      clr_q, clr_d;
  logic [BIN_W:0]         rd_idx_q, rd_idx_d;
  logic                   pv_q, pv_d;
  logic [BIN_W-1:0]       pidx_q, pidx_d;
  logic                   found_q, found_d;

  llhq_pkg::action_e      act_q, act_d;
  logic [1:0]             axis_q, axis_d;
  logic [MAG_W-1:0]       mag_q, mag_d;
  logic [P_W-1:0]         p_q, p_d;

  logic [TOT_W-1:0]       tot_q, tot_d;
  logic [TOT_W-1:0]       cum_q, cum_d;
  logic [W10-1:0]         nine_q, nine_d;
  logic [TG_W-1:0]        tgt_q, tgt_d;
  logic [LVL_W-1:0]       lo_q, lo_d;
  logic [CNT_W-1:0]       hcnt_q, hcnt_d;

  logic [LVL_W-1:0]       r_lvl_q, r_lvl_d, r_tail_q, r_tail_d;
  logic                   r_emp_q, r_emp_d, r_bad_q, r_bad_d;
  logic                   m_valid_q, m_valid_d;
  logic [39:0]            m_data_q, m_data_d;
  logic [1:0]             m_user_q, m_user_d;

  logic                   we;
  logic [ADDR_W-1:0]      waddr, raddr, base;
  logic [CNT_W-1:0]       wdata, rdata;
  llhq_pkg::md_cmd_t      md_cmd;
  llhq_pkg::md_rsp_t      md_rsp;

  logic                   last;
  logic [BIN_W:0]         nidx;
  logic [TOT_W-1:0]       cn;
  logic [TG_W-1:0]        next_q;
  logic [LVL_W-1:0]       hi;
  logic [W10-1:0]         cn10;

  llhq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (llhq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  llhq_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (md_cmd),
    .rsp_o  (md_rsp)
  );

  // Clamped shift
  always_comb begin
    if (shift_q < llhq_pkg::SHIFT_MIN) begin
      sh = llhq_pkg::SHIFT_MIN;
    end else if (shift_q > llhq_pkg::SHIFT_MAX) begin
      sh = llhq_pkg::SHIFT_MAX;
    end else begin
      sh = shift_q;
    end
  end

  assign base   = ADDR_W'(ADDR_W'(axis_q) * ADDR_W'(NB));
  assign raddr  = base + ADDR_W'(rd_idx_q[BIN_W-1:0]);
  assign last   = (pidx_q == BIN_W'(NB - 1));
  assign nidx   = {1'b0, pidx_q} + 1'b1;
  assign hi     = llhq_pkg::edge_at(nidx);
  assign cn     = cum_q + TOT_W'(rdata);
  assign next_q = TG_W'(cn);
  assign cn10   = (W10'(cn) << 3) + (W10'(cn) << 1) + W10'(9);

  assign s_axis_tready = (state_q == llhq_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    rd_idx_d  = rd_idx_q;
    pv_d      = 1'b0;
    pidx_d    = rd_idx_q[BIN_W-1:0];
    found_d   = found_q;
    act_d     = act_q;
    axis_d    = axis_q;
    mag_d     = mag_q;
    p_d       = p_q;
    tot_d     = tot_q;
    cum_d     = cum_q;
    nine_d    = nine_q;
    tgt_d     = tgt_q;
    lo_d      = lo_q;
    hcnt_d    = hcnt_q;
    r_lvl_d   = r_lvl_q;
    r_tail_d  = r_tail_q;
    r_emp_d   = r_emp_q;
    r_bad_d   = r_bad_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    we        = 1'b0;
    waddr     = base + ADDR_W'(pidx_q);
    wdata     = '0;
    md_cmd    = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // bin read issue shared by all scans
    if ((state_q == llhq_pkg::ST_ADD || state_q == llhq_pkg::ST_SUM ||
         state_q == llhq_pkg::ST_QSCAN || state_q == llhq_pkg::ST_TSCAN) &&
        (int'(rd_idx_q) < NB)) begin
      rd_idx_d = rd_idx_q + 1'b1;
      pv_d     = 1'b1;
    end

    case (state_q)
      llhq_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(llhq_pkg::DEPTH - 1)) begin
          state_d = llhq_pkg::ST_IDLE;
        end
      end
      llhq_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d    = llhq_pkg::action_e'(s_axis_tuser);
          axis_d   = s_axis_tdata[1:0];
          mag_d    = s_axis_tdata[21:2];
          p_d      = s_axis_tdata[38:22];
          rd_idx_d = '0;
          found_d  = 1'b0;
          tot_d    = '0;
          r_lvl_d  = '0;
          r_tail_d = '0;
          r_emp_d  = 1'b0;
          r_bad_d  = 1'b0;
          if (llhq_pkg::action_e'(s_axis_tuser) == llhq_pkg::ACT_NONE) begin
            state_d = llhq_pkg::ST_DONE;
          end else if (int'(s_axis_tdata[1:0]) >= llhq_pkg::NUM_AXES) begin
            r_bad_d = 1'b1;
            state_d = llhq_pkg::ST_DONE;
          end else if (llhq_pkg::action_e'(s_axis_tuser) == llhq_pkg::ACT_ADD) begin
            state_d = llhq_pkg::ST_ADD;
          end else begin
            state_d = llhq_pkg::ST_SUM;
          end
        end
      end
      llhq_pkg::ST_ADD: begin
        // leak each bin, add the increment at the sample's bin
        if (pv_q) begin
          we    = 1'b1;
          wdata = rdata - (rdata >> sh);
          if (!found_q && ((mag_q <= MAG_W'(hi)) || last)) begin
            found_d = 1'b1;
            wdata   = wdata + (CNT_W'(1) << sh);
          end
          if (last) begin
            pv_d    = 1'b0;
            state_d = llhq_pkg::ST_DONE;
          end
        end
      end
      llhq_pkg::ST_SUM: begin
        if (pv_q) begin
          tot_d = tot_q + TOT_W'(rdata);
          if (last) begin
            pv_d     = 1'b0;
            rd_idx_d = '0;
            cum_d    = '0;
            if (tot_d == '0) begin
              r_emp_d = 1'b1;
              if (act_q == llhq_pkg::ACT_QUANT) begin
                r_lvl_d = llhq_pkg::edge_at('0);
              end
              state_d = llhq_pkg::ST_DONE;
            end else if (act_q == llhq_pkg::ACT_QUANT) begin
              md_cmd.go = 1'b1;
              md_cmd.op = llhq_pkg::MD_MUL;
              md_cmd.x  = PROD_W'(p_q);
              md_cmd.y  = tot_d;
              state_d   = llhq_pkg::ST_QMUL;
            end else begin
              nine_d  = (W10'(tot_d) << 3) + W10'(tot_d);
              state_d = llhq_pkg::ST_TSCAN;
            end
          end
        end
      end
      llhq_pkg::ST_QMUL: begin
        pv_d = 1'b0;
        if (md_rsp.done) begin
          tgt_d    = TG_W'((md_rsp.res + PROD_W'(32768)) >> 16);
          rd_idx_d = '0;
          state_d  = llhq_pkg::ST_QSCAN;
        end
      end
      llhq_pkg::ST_QSCAN: begin
        if (pv_q) begin
          if ((rdata != '0) && (next_q >= tgt_q)) begin
            lo_d      = llhq_pkg::edge_at({1'b0, pidx_q});
            hcnt_d    = rdata;
            md_cmd.go = 1'b1;
            md_cmd.op = llhq_pkg::MD_MUL;
            md_cmd.x  = PROD_W'(hi - llhq_pkg::edge_at({1'b0, pidx_q}));
            md_cmd.y  = (tgt_q > TG_W'(cum_q)) ? TOT_W'(tgt_q - TG_W'(cum_q)) : '0;
            pv_d      = 1'b0;
            state_d   = llhq_pkg::ST_QMUL2;
          end else begin
            cum_d = cn;
            if (last) begin
              pv_d    = 1'b0;
              r_lvl_d = llhq_pkg::TOP_LEVEL;
              state_d = llhq_pkg::ST_DONE;
            end
          end
        end
      end
      llhq_pkg::ST_QMUL2: begin
        pv_d = 1'b0;
        if (md_rsp.done) begin
          md_cmd.go = 1'b1;
          md_cmd.op = llhq_pkg::MD_DIV;
          md_cmd.x  = md_rsp.res;
          md_cmd.y  = TOT_W'(hcnt_q);
          state_d   = llhq_pkg::ST_QDIV;
        end
      end
      llhq_pkg::ST_QDIV: begin
        pv_d = 1'b0;
        if (md_rsp.done) begin
          r_lvl_d = lo_q + LVL_W'(md_rsp.res);
          state_d = llhq_pkg::ST_DONE;
        end
      end
      llhq_pkg::ST_TSCAN: begin
        // cum >= floor(9t/10) is the same as 9t <= 10*cum + 9
        if (pv_q) begin
          cum_d = cn;
          if ((nine_q <= cn10) || last) begin
            md_cmd.go = 1'b1;
            md_cmd.op = llhq_pkg::MD_DIV;
            md_cmd.x  = PROD_W'({tot_q - cn, 16'b0});
            md_cmd.y  = tot_q;
            pv_d      = 1'b0;
            state_d   = llhq_pkg::ST_TDIV;
          end
        end
      end
      llhq_pkg::ST_TDIV: begin
        pv_d = 1'b0;
        if (md_rsp.done) begin
          r_tail_d = LVL_W'(md_rsp.res);
          state_d  = llhq_pkg::ST_DONE;
        end
      end
      llhq_pkg::ST_DONE: begin
        pv_d = 1'b0;
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'b0, r_tail_q, r_lvl_q};
          m_user_d  = {r_bad_q, r_emp_q};
          state_d   = llhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = llhq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= llhq_pkg::ST_CLEAR;
      clr_q     <= '0;
      rd_idx_q  <= '0;
      pv_q      <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
      shift_q   <= llhq_pkg::SHIFT_RST;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_idx_q  <= rd_idx_d;
      pv_q      <= pv_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        shift_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    act_q    <= act_d;
    axis_q   <= axis_d;
    mag_q    <= mag_d;
    p_q      <= p_d;
    tot_q    <= tot_d;
    cum_q    <= cum_d;
    nine_q   <= nine_d;
    tgt_q    <= tgt_d;
    lo_q     <= lo_d;
    hcnt_q   <= hcnt_d;
    r_lvl_q  <= r_lvl_d;
    r_tail_q <= r_tail_d;
    r_emp_q  <= r_emp_d;
    r_bad_q  <= r_bad_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Shared unit only answers while the sequencer waits for it
  a_md_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (state_q == llhq_pkg::ST_QMUL || state_q == llhq_pkg::ST_QMUL2 ||
                     state_q == llhq_pkg::ST_QDIV || state_q == llhq_pkg::ST_TDIV))
    else $error("muldiv result outside a wait state");

  // Counters are written only by the clearing pass and by add sample
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == llhq_pkg::ST_CLEAR || state_q == llhq_pkg::ST_ADD))
    else $error("bin write outside clear or add");

  // A bad axis result carries no level or tail
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("bad axis word with payload");

  // The unit never signals done straight after taking a new command
  a_md_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_cmd.go |=> !md_rsp.done)
    else $error("muldiv restarted early");

endmodule

// ===== src/llhq_ram.sv =====
module llhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/llhq_muldiv.sv =====
module llhq_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llhq_pkg::md_cmd_t cmd_i,
  output llhq_pkg::md_rsp_t rsp_o
);

  localparam int ITER   = llhq_pkg::ITER;
  localparam int PROD_W = llhq_pkg::PROD_W;
  localparam int TOT_W  = llhq_pkg::TOT_W;
  localparam int C_W    = $clog2(ITER);

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [C_W-1:0]      cnt_q, cnt_d;
  llhq_pkg::md_op_e    op_q, op_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [ITER-1:0]     sh_q, sh_d;
  logic [TOT_W-1:0]    y_q, y_d;
  logic [TOT_W:0]      trial;

  // One shift-add or shift-subtract step per cycle, ITER steps per command
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    y_d    = y_q;
    trial  = {acc_q[TOT_W-1:0], sh_q[ITER-1]};
    if (cmd_i.go) begin
      run_d = 1'b1;
      cnt_d = '0;
      op_d  = cmd_i.op;
      y_d   = cmd_i.y;
      sh_d  = cmd_i.x[ITER-1:0];
      if (cmd_i.op == llhq_pkg::MD_DIV) begin
        // dividend is known to keep the quotient below 2^ITER
        acc_d = cmd_i.x >> ITER;
      end else begin
        acc_d = '0;
      end
    end else if (run_q) begin
      if (op_q == llhq_pkg::MD_MUL) begin
        acc_d = (acc_q << 1) + (sh_q[ITER-1] ? PROD_W'(y_q) : '0);
        sh_d  = sh_q << 1;
      end else begin
        if (trial >= {1'b0, y_q}) begin
          acc_d = PROD_W'(trial - {1'b0, y_q});
          sh_d  = {sh_q[ITER-2:0], 1'b1};
        end else begin
          acc_d = PROD_W'(trial);
          sh_d  = {sh_q[ITER-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == C_W'(ITER - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= llhq_pkg::MD_MUL;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    y_q   <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == llhq_pkg::MD_DIV) ? PROD_W'(sh_q) : acc_q;

endmodule

// ===== sim/leaky_log_histogram_quantile_tb.sv =====
`timescale 1ns / 1ps

module leaky_log_histogram_quantile_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;

  // Expected result of one input word
  typedef struct packed {
    logic [llhq_pkg::LVL_W-1:0] level;
    logic [llhq_pkg::LVL_W-1:0] tail_frac;
    logic                       empty;
    logic                       bad_axis;
  } hist_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;

  leaky_log_histogram_quantile u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the block state
  logic [llhq_pkg::CNT_W-1:0] shadow_bins [llhq_pkg::NUM_AXES][llhq_pkg::NUM_BINS];
  logic [llhq_pkg::SH_W-1:0]  shadow_shift;
  hist_result_t               pending_results [$];

  int  error_count;
  int  idle_pct_src;
  int  idle_pct_snk;
  int  hold_req;
  int  hold_seen;
  int  hold_cnt;
  int  quiet_cycles;
  bit  timed_out;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predictor helpers
  function automatic longint unsigned bin_edge(int i);
    if (i >= llhq_pkg::NUM_BINS) return 64'(llhq_pkg::TOP_LEVEL);
    return 64'(llhq_pkg::EDGE_TABLE[(i * llhq_pkg::EDGE_STEPS) / llhq_pkg::NUM_BINS]);
  endfunction

  function automatic int bin_of(logic [llhq_pkg::MAG_W-1:0] mag);
    int i;
    i = 0;
    while (i < llhq_pkg::NUM_BINS - 1 && 64'(mag) > bin_edge(i + 1)) i++;
    return i;
  endfunction

  function automatic hist_result_t predict_word(llhq_pkg::action_e act, logic [1:0] ax,
                                                logic [llhq_pkg::MAG_W-1:0] mag,
                                                logic [llhq_pkg::P_W-1:0] p);
    hist_result_t r;
    longint unsigned total, target, cum, nxt, part, span;
    int sh, b;
    bit found;
    r = '0;
    if (act == llhq_pkg::ACT_NONE) return r;
    if (ax >= llhq_pkg::NUM_AXES) begin
      r.bad_axis = 1'b1;
      return r;
    end
    if (act == llhq_pkg::ACT_ADD) begin
      sh = int'(shadow_shift);
      if (sh < int'(llhq_pkg::SHIFT_MIN)) sh = int'(llhq_pkg::SHIFT_MIN);
      if (sh > int'(llhq_pkg::SHIFT_MAX)) sh = int'(llhq_pkg::SHIFT_MAX);
      for (int i = 0; i < llhq_pkg::NUM_BINS; i++)
        shadow_bins[ax][i] = shadow_bins[ax][i] - (shadow_bins[ax][i] >> sh);
      b = bin_of(mag);
      shadow_bins[ax][b] = shadow_bins[ax][b] + (32'd1 << sh);
      return r;
    end
    total = 0;
    for (int i = 0; i < llhq_pkg::NUM_BINS; i++) total += 64'(shadow_bins[ax][i]);
    if (total == 0) begin
      r.empty = 1'b1;
      if (act == llhq_pkg::ACT_QUANT) r.level = llhq_pkg::LVL_W'(bin_edge(0));
      return r;
    end
    cum = 0;
    if (act == llhq_pkg::ACT_QUANT) begin
      target = (64'(p) * total + 64'd32768) >> 16;
      r.level = llhq_pkg::TOP_LEVEL;
      found = 1'b0;
      for (int i = 0; i < llhq_pkg::NUM_BINS && !found; i++) begin
        nxt = cum + 64'(shadow_bins[ax][i]);
        if (nxt >= target && shadow_bins[ax][i] > 0) begin
          span = bin_edge(i + 1) - bin_edge(i);
          part = (target > cum) ? target - cum : 64'd0;
          r.level = llhq_pkg::LVL_W'(bin_edge(i) + (span * part) / shadow_bins[ax][i]);
          found = 1'b1;
        end
        cum = nxt;
      end
    end else begin
      target = total * 9 / 10;
      for (int i = 0; i < llhq_pkg::NUM_BINS; i++) begin
        cum += 64'(shadow_bins[ax][i]);
        if (cum >= target) break;
      end
      r.tail_frac = llhq_pkg::LVL_W'(((total - cum) << 16) / total);
    end
    return r;
  endfunction

  // Send one word; prediction is made at acceptance, valid stays up until
  // the next falling edge decides between a new word and an idle cycle
  task automatic send_word(llhq_pkg::action_e act, logic [1:0] ax,
                           logic [llhq_pkg::MAG_W-1:0] mag,
                           logic [llhq_pkg::P_W-1:0] p);
    while (idle_pct_src > 0 && $urandom_range(99, 0) < idle_pct_src) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, p, mag, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_word(act, ax, mag, p));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_shift(logic [llhq_pkg::SH_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_shift = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Random word, mostly valid adds and queries
  task automatic send_random();
    llhq_pkg::action_e act;
    logic [1:0] ax;
    logic [llhq_pkg::MAG_W-1:0] mag;
    logic [llhq_pkg::P_W-1:0] p;
    int r;
    r = $urandom_range(99, 0);
    act = (r < 55) ? llhq_pkg::ACT_ADD : (r < 75) ? llhq_pkg::ACT_QUANT :
          (r < 95) ? llhq_pkg::ACT_TAIL : llhq_pkg::ACT_NONE;
    ax = ($urandom_range(19, 0) == 0) ? 2'd3 : 2'($urandom_range(2, 0));
    case ($urandom_range(3, 0))
      0:       mag = llhq_pkg::MAG_W'($urandom);
      1:       mag = llhq_pkg::MAG_W'($urandom_range(65536, 0));
      default: mag = llhq_pkg::MAG_W'(llhq_pkg::EDGE_TABLE[$urandom_range(32, 0)] +
                                      $urandom_range(2, 0) - 1);
    endcase
    p = ($urandom_range(9, 0) == 0) ? llhq_pkg::P_W'($urandom) :
                                      llhq_pkg::P_W'($urandom_range(65536, 0));
    send_word(act, ax, mag, p);
  endtask

  task automatic test_directed();
    send_word(llhq_pkg::ACT_QUANT, 2'd0, '0, 17'd32768);
    send_word(llhq_pkg::ACT_TAIL, 2'd1, '0, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd3, 20'hFFFFF, 17'h1FFFF);
    send_word(llhq_pkg::ACT_NONE, 2'd0, 20'hFFFFF, 17'h1FFFF);
    send_word(llhq_pkg::ACT_ADD, 2'd0, '0, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd0, 20'hFFFFF, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd0, 20'd64, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd0, 20'd65, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd0, 20'd65536, '0);
    send_word(llhq_pkg::ACT_ADD, 2'd1, 20'd2048, '0);
    send_word(llhq_pkg::ACT_QUANT, 2'd0, '0, '0);
    send_word(llhq_pkg::ACT_QUANT, 2'd0, '0, 17'd65536);
    send_word(llhq_pkg::ACT_QUANT, 2'd0, '0, 17'h1FFFF);
    send_word(llhq_pkg::ACT_QUANT, 2'd1, '0, 17'd16384);
    send_word(llhq_pkg::ACT_TAIL, 2'd0, '0, '0);
    send_word(llhq_pkg::ACT_TAIL, 2'd1, '0, '0);
    send_word(llhq_pkg::ACT_QUANT, 2'd3, '0, '0);
    send_word(llhq_pkg::ACT_TAIL, 2'd2, '0, '0);
  endtask

  task automatic test_shift_settings();
    logic [llhq_pkg::SH_W-1:0] shifts [6] = '{5'd1, 5'd20, 5'd0, 5'd31, 5'd4, 5'd11};
    foreach (shifts[k]) begin
      write_shift(shifts[k]);
      repeat (40) send_random();
    end
  endtask

  task automatic test_random();
    repeat (500) begin
      if ($urandom_range(99, 0) == 0) write_shift(llhq_pkg::SH_W'($urandom));
      send_random();
    end
  endtask

  // Continuous stream with no idling while the receiver holds off
  task automatic test_backpressure();
    idle_pct_src = 0;
    hold_req     = hold_req + 1;
    repeat (40) send_random();
    idle_pct_src = 28;
  endtask

  // Receiver: random stalls, with a long hold on each request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_cnt      <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= idle_pct_snk);
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    hist_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[16:0] !== want.level)
            report_mismatch("level", m_axis_tdata[16:0], want.level);
          if (m_axis_tdata[33:17] !== want.tail_frac)
            report_mismatch("tail_fraction", m_axis_tdata[33:17], want.tail_frac);
          if (m_axis_tuser[0] !== want.empty)
            report_mismatch("hist_empty", m_axis_tuser[0], want.empty);
          if (m_axis_tuser[1] !== want.bad_axis)
            report_mismatch("bad_axis", m_axis_tuser[1], want.bad_axis);
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    idle_pct_src  = 28;
    idle_pct_snk  = 28;
    hold_req      = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    shadow_shift  = llhq_pkg::SHIFT_RST;
    foreach (shadow_bins[a, b]) shadow_bins[a][b] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_shift_settings();
    // stretch with no idling on either side
    idle_pct_src = 0;
    idle_pct_snk = 0;
    repeat (60) send_random();
    idle_pct_src = 28;
    idle_pct_snk = 28;
    test_random();
    wait_drained();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
